### sv/assert_macros.svh
// Assertion macros shared by the wave cycle byte decoder RTL.
// Each macro samples on clk and is disabled while rst is high.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// The expression holds at every clock edge.
`define ASSERT_ALWAYS(label, expr, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (expr)) else $error(msg);

// The consequent holds in the same cycle as the antecedent.
`define ASSERT_IMPLIES(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);

// The consequent holds in the cycle after the antecedent.
`define ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

`endif

### sv/wcbd_pkg.sv
// Types, constants and helper functions for the wave cycle byte decoder.
// Used by wcbd_core and wave_cycle_byte_decoder; depends on nothing else.
package wcbd_pkg;

  localparam int DUR_W = 16;
  localparam int CFG_W = 14;
  localparam int VAL_W = (DUR_W > CFG_W + 2) ? DUR_W : CFG_W + 2;
  localparam int ADDR_W = 4;
  localparam int FIFO_DEPTH = 4;
  localparam int PTR_W = $clog2(FIFO_DEPTH);
  localparam int CNT_W = $clog2(FIFO_DEPTH + 1);

  typedef logic [DUR_W-1:0] dur_t;
  typedef logic [CFG_W-1:0] cfg_t;
  typedef logic [VAL_W-1:0] val_t;

  localparam cfg_t BIT_PERIOD_RST = CFG_W'(66);
  localparam cfg_t SNAP_MARGIN_RST = CFG_W'(44);
  localparam cfg_t TOLERANCE_RST = CFG_W'(7);

  localparam logic [1:0] REG_BIT_PERIOD = 2'd0;
  localparam logic [1:0] REG_SNAP_MARGIN = 2'd1;
  localparam logic [1:0] REG_TOLERANCE = 2'd2;

  localparam logic [3:0] PH_PROLOG = 4'd0;
  localparam logic [3:0] PH_FIRST_BIT = 4'd1;
  localparam logic [3:0] PH_PARITY = 4'd9;
  localparam logic [3:0] PH_EPILOG = 4'd10;

  typedef enum logic [2:0] {
    EV_PROLOG     = 3'd0,
    EV_BYTE       = 3'd1,
    EV_BAD_PROLOG = 3'd2,
    EV_BAD_PARITY = 3'd3,
    EV_BAD_EPILOG = 3'd4
  } evt_t;

  typedef struct packed {
    evt_t       evt;
    logic [7:0] byte_value;
    logic       last;
  } result_t;

  // Up to two results caused by one input item, in delivery order.
  typedef struct packed {
    logic [1:0] cnt;
    result_t    r0;
    result_t    r1;
  } res_pair_t;

  // Rounds a duration to one, two or three bit periods.
  function automatic val_t snap(dur_t v, cfg_t p, cfg_t m);
    cfg_t               mm;
    logic [CFG_W+1:0]   p1;
    logic [CFG_W+1:0]   p2;
    logic [CFG_W+1:0]   p3;
    val_t               vv;
    mm = (m < p) ? m : p;
    p1 = {2'b00, p} + {2'b00, mm};
    p2 = {1'b0, p, 1'b0} + {2'b00, mm};
    p3 = {1'b0, p, 1'b0} + {2'b00, p};
    vv = VAL_W'(v);
    if (vv < VAL_W'(p1)) return VAL_W'(p);
    if (vv < VAL_W'(p2)) return VAL_W'({1'b0, p, 1'b0});
    return VAL_W'(p3);
  endfunction

  // True when the two values differ by at most the tolerance.
  function automatic logic near(val_t a, val_t b, cfg_t tol);
    val_t d;
    d = (a > b) ? a - b : b - a;
    return d <= VAL_W'(tol);
  endfunction

endpackage

### sv/wcbd_core.sv
// Decoder state and per-cycle decision logic: snapping, history, prolog
// test, data bit shifting and epilog check. Depends on wcbd_pkg.
`include "assert_macros.svh"

module wcbd_core (
  input  logic                clk,
  input  logic                rst,
  input  logic                advance,
  input  wcbd_pkg::dur_t      low_time,
  input  wcbd_pkg::dur_t      high_time,
  input  wcbd_pkg::cfg_t      bit_period,
  input  wcbd_pkg::cfg_t      snap_margin,
  input  wcbd_pkg::cfg_t      tolerance,
  output wcbd_pkg::res_pair_t res
);

  logic [3:0]     phase, phase_next;
  logic [7:0]     shift_byte, shift_byte_next;
  logic           parity_seen, parity_seen_next;
  wcbd_pkg::val_t epi_low, epi_low_next;
  wcbd_pkg::val_t epi_high, epi_high_next;
  wcbd_pkg::val_t hist_low [2];
  wcbd_pkg::val_t hist_high [2];
  logic           newest_slot;
  logic [1:0]     hist_fill, hist_fill_next;

  logic [3:0]     cur_phase;
  logic           do_push;
  wcbd_pkg::val_t snap_low, snap_high;
  wcbd_pkg::val_t old_low, old_high;
  logic [1:0]     fill_pushed, fill_after;
  logic           pro_pass, epi_match, parity_ok;
  wcbd_pkg::evt_t pro_evt;

  assign cur_phase = (phase > wcbd_pkg::PH_EPILOG) ? wcbd_pkg::PH_PROLOG : phase;
  assign do_push = (cur_phase == wcbd_pkg::PH_PROLOG) || (cur_phase == wcbd_pkg::PH_EPILOG);
  assign snap_low = wcbd_pkg::snap(low_time, bit_period, snap_margin);
  assign snap_high = wcbd_pkg::snap(high_time, bit_period, snap_margin);

  // After the push the current newest entry becomes the older one.
  assign old_low = hist_low[newest_slot];
  assign old_high = hist_high[newest_slot];
  assign fill_pushed = (hist_fill == 2'd2) ? 2'd2 : hist_fill + 2'd1;

  assign pro_pass = wcbd_pkg::near(snap_low, old_low >> 1, tolerance) &&
                    wcbd_pkg::near(snap_high, old_high >> 1, tolerance) &&
                    wcbd_pkg::near(old_high, old_low, tolerance) &&
                    wcbd_pkg::near(snap_high, snap_low, tolerance);
  assign pro_evt = pro_pass ? wcbd_pkg::EV_PROLOG : wcbd_pkg::EV_BAD_PROLOG;
  assign epi_match = wcbd_pkg::near(epi_low, snap_low, tolerance) &&
                     wcbd_pkg::near(epi_high, snap_high, tolerance);
  // Odd parity over the byte and its parity bit.
  assign parity_ok = (~(^shift_byte)) == parity_seen;
  assign fill_after = (epi_match && parity_ok) ? 2'd0 : fill_pushed;

  always_comb begin
    phase_next = cur_phase;
    shift_byte_next = shift_byte;
    parity_seen_next = parity_seen;
    epi_low_next = epi_low;
    epi_high_next = epi_high;
    hist_fill_next = do_push ? fill_pushed : hist_fill;
    res = '0;
    res.r0.evt = wcbd_pkg::EV_PROLOG;
    res.r1.evt = wcbd_pkg::EV_PROLOG;
    priority if (cur_phase == wcbd_pkg::PH_PROLOG) begin
      if (fill_pushed == 2'd2) begin
        epi_high_next = '0;
        res.cnt = 2'd1;
        res.r0.evt = pro_evt;
        res.r0.last = 1'b1;
        if (pro_pass) begin
          phase_next = wcbd_pkg::PH_FIRST_BIT;
          hist_fill_next = 2'd0;
        end
      end
    end else if (cur_phase < wcbd_pkg::PH_PARITY) begin
      for (int i = 0; i < 8; i++) begin
        if ((cur_phase == 4'(i + 1)) && (high_time > low_time)) begin
          shift_byte_next[i] = 1'b1;
        end
      end
      phase_next = cur_phase + 4'd1;
    end else if (cur_phase == wcbd_pkg::PH_PARITY) begin
      parity_seen_next = high_time > low_time;
      phase_next = cur_phase + 4'd1;
    end else if (epi_high == '0) begin
      // A zero high value marks the first epilog cycle as not yet captured.
      epi_high_next = snap_high;
      epi_low_next = snap_low;
    end else begin
      if (!epi_match) begin
        res.r0.evt = wcbd_pkg::EV_BAD_EPILOG;
      end else if (!parity_ok) begin
        res.r0.evt = wcbd_pkg::EV_BAD_PARITY;
      end else begin
        res.r0.evt = wcbd_pkg::EV_BYTE;
        res.r0.byte_value = shift_byte;
      end
      phase_next = wcbd_pkg::PH_PROLOG;
      shift_byte_next = '0;
      hist_fill_next = fill_after;
      // The prolog test runs again on the same history.
      if (fill_after == 2'd2) begin
        epi_high_next = '0;
        res.cnt = 2'd2;
        res.r1.evt = pro_evt;
        res.r1.last = 1'b1;
        if (pro_pass) begin
          phase_next = wcbd_pkg::PH_FIRST_BIT;
          hist_fill_next = 2'd0;
        end
      end else begin
        res.cnt = 2'd1;
        res.r0.last = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase <= wcbd_pkg::PH_PROLOG;
      shift_byte <= '0;
      parity_seen <= 1'b0;
      epi_low <= '0;
      epi_high <= '0;
      hist_low[0] <= '0;
      hist_low[1] <= '0;
      hist_high[0] <= '0;
      hist_high[1] <= '0;
      newest_slot <= 1'b0;
      hist_fill <= 2'd0;
    end else if (advance) begin
      phase <= phase_next;
      shift_byte <= shift_byte_next;
      parity_seen <= parity_seen_next;
      epi_low <= epi_low_next;
      epi_high <= epi_high_next;
      hist_fill <= hist_fill_next;
      if (do_push) begin
        newest_slot <= ~newest_slot;
        hist_low[~newest_slot] <= snap_low;
        hist_high[~newest_slot] <= snap_high;
      end
    end
  end

  `ASSERT_ALWAYS(a_phase_range, phase <= wcbd_pkg::PH_EPILOG, "phase left its range")
  `ASSERT_IMPLIES(a_two_only_from_epilog, advance && (res.cnt == 2'd2), cur_phase == wcbd_pkg::PH_EPILOG, "two results outside the epilog")
  `ASSERT_NEXT(a_prolog_starts_data, advance && (res.cnt != 2'd0) && pro_pass && (cur_phase == wcbd_pkg::PH_PROLOG), (phase == wcbd_pkg::PH_FIRST_BIT) && (hist_fill == 2'd0), "prolog did not start data phase")

endmodule

### sv/wave_cycle_byte_decoder.sv
// Wave cycle byte decoder top: APB registers, input stage and result queue around
// wcbd_core; depends on wcbd_pkg and assert_macros.svh.
// Path: an accepted request is held in the input stage register, then its results are written into the result queue.
// Throughput: one request per cycle while the four-entry queue has room for two
// more results; a request that yields two results has them leave the queue one after the other.
// Reset (rst, synchronous) loads register defaults, empties stage and queue, awaits a prolog.
`include "assert_macros.svh"

module wave_cycle_byte_decoder (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        psel,
  input  logic                        penable,
  input  logic                        pwrite,
  input  logic [wcbd_pkg::ADDR_W-1:0] paddr,
  input  logic [31:0]                 pwdata,
  output logic [31:0]                 prdata,
  output logic                        pready,
  input  logic                        s_axis_tvalid,
  output logic                        s_axis_tready,
  input  logic [31:0]                 s_axis_tdata,   // low_time[15:0], high_time[31:16]
  output logic                        m_axis_tvalid,
  input  logic                        m_axis_tready,
  output logic [15:0]                 m_axis_tdata,   // event_res[2:0], byte_value[10:3]
  output logic                        m_axis_tlast
);

  wcbd_pkg::cfg_t bit_period, snap_margin, tolerance;
  logic           cfg_write;

  logic           in_valid;
  wcbd_pkg::dur_t in_low, in_high;
  logic           advance;
  logic           in_accept;

  wcbd_pkg::res_pair_t res;
  wcbd_pkg::result_t   fifo [wcbd_pkg::FIFO_DEPTH];
  logic [wcbd_pkg::PTR_W-1:0] wr_ptr, rd_ptr;
  logic [wcbd_pkg::CNT_W-1:0] fifo_count;
  logic [1:0]                 push_n;
  logic                       pop;
  wcbd_pkg::result_t          head;
  logic                       queue_over;
  logic                       last_pop;

  assign pready = 1'b1;
  assign cfg_write = psel && penable && pwrite && pready;

  always_ff @(posedge clk) begin
    if (rst) begin
      bit_period <= wcbd_pkg::BIT_PERIOD_RST;
      snap_margin <= wcbd_pkg::SNAP_MARGIN_RST;
      tolerance <= wcbd_pkg::TOLERANCE_RST;
    end else if (cfg_write) begin
      unique case (paddr[3:2])
        wcbd_pkg::REG_BIT_PERIOD:  bit_period <= pwdata[wcbd_pkg::CFG_W-1:0];
        wcbd_pkg::REG_SNAP_MARGIN: snap_margin <= pwdata[wcbd_pkg::CFG_W-1:0];
        wcbd_pkg::REG_TOLERANCE:   tolerance <= pwdata[wcbd_pkg::CFG_W-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (paddr[3:2])
      wcbd_pkg::REG_BIT_PERIOD:  prdata = 32'(bit_period);
      wcbd_pkg::REG_SNAP_MARGIN: prdata = 32'(snap_margin);
      wcbd_pkg::REG_TOLERANCE:   prdata = 32'(tolerance);
      default:                   prdata = '0;
    endcase
  end

  // The stage advances when it holds a request and the queue can take two more results.
  assign advance = in_valid && (fifo_count <= wcbd_pkg::CNT_W'(wcbd_pkg::FIFO_DEPTH - 2));
  assign s_axis_tready = !in_valid || advance;
  assign in_accept = s_axis_tvalid && s_axis_tready;

  always_ff @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else if (in_accept) begin
      in_valid <= 1'b1;
    end else if (advance) begin
      in_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_accept) begin
      in_low <= s_axis_tdata[15:0];
      in_high <= s_axis_tdata[31:16];
    end
  end

  wcbd_core u_core (
    .clk         (clk),
    .rst         (rst),
    .advance     (advance),
    .low_time    (in_low),
    .high_time   (in_high),
    .bit_period  (bit_period),
    .snap_margin (snap_margin),
    .tolerance   (tolerance),
    .res         (res)
  );

  assign push_n = advance ? res.cnt : 2'd0;
  assign pop = m_axis_tvalid && m_axis_tready;
  assign head = fifo[rd_ptr];

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      fifo_count <= '0;
    end else begin
      wr_ptr <= wr_ptr + wcbd_pkg::PTR_W'(push_n);
      rd_ptr <= rd_ptr + wcbd_pkg::PTR_W'(pop);
      fifo_count <= fifo_count + wcbd_pkg::CNT_W'(push_n) - wcbd_pkg::CNT_W'(pop);
    end
  end

  always_ff @(posedge clk) begin
    if (push_n != 2'd0) begin
      fifo[wr_ptr] <= res.r0;
    end
    if (push_n == 2'd2) begin
      fifo[wr_ptr + wcbd_pkg::PTR_W'(1)] <= res.r1;
    end
  end

  assign m_axis_tvalid = fifo_count != '0;
  assign m_axis_tdata = {5'b0, head.byte_value, head.evt};
  assign m_axis_tlast = head.last;

  assign queue_over = fifo_count > wcbd_pkg::CNT_W'(wcbd_pkg::FIFO_DEPTH);
  assign last_pop = pop && (fifo_count == wcbd_pkg::CNT_W'(1)) && (push_n == 2'd0);

  `ASSERT_ALWAYS(a_fifo_bound, !queue_over, "result queue overflow")
  `ASSERT_NEXT(a_fifo_drains, last_pop, !m_axis_tvalid, "queue not empty after last pop")

endmodule

### dv/wcbd_frame_check_pkg.sv
// Frame checker for the wave cycle byte decoder testbench: predicts the events
// that each accepted wave cycle causes and compares them with the output stream.
// Depends on wcbd_pkg for the register indexes, phases and event codes.
package wcbd_frame_check_pkg;

  import wcbd_pkg::*;

  class byte_frame_checker;

    cfg_t       period;
    cfg_t       margin;
    cfg_t       tol;
    logic [3:0] phase;
    logic [7:0] shift_byte;
    logic       parity_bit;
    dur_t       epi_low;
    dur_t       epi_high;
    dur_t       hist_low[2];
    dur_t       hist_high[2];
    logic       newest;
    logic [1:0] fill;
    result_t    item_events[$];
    result_t    expected_events[$];
    int         errors;

    function new();
      period = BIT_PERIOD_RST;
      margin = SNAP_MARGIN_RST;
      tol = TOLERANCE_RST;
      phase = PH_PROLOG;
      shift_byte = '0;
      parity_bit = 1'b0;
      epi_low = '0;
      epi_high = '0;
      hist_low = '{'0, '0};
      hist_high = '{'0, '0};
      newest = 1'b0;
      fill = '0;
      errors = 0;
    endfunction

    // Only bits 13:0 of the write data reach a register.
    function void write_reg(int idx, logic [31:0] value);
      if (idx == REG_BIT_PERIOD) period = value[CFG_W-1:0];
      else if (idx == REG_SNAP_MARGIN) margin = value[CFG_W-1:0];
      else if (idx == REG_TOLERANCE) tol = value[CFG_W-1:0];
    endfunction

    function int outstanding();
      return expected_events.size();
    endfunction

    function dur_t snap_dur(dur_t v);
      int unsigned p;
      int unsigned m;
      p = period;
      m = (margin < period) ? margin : period;
      if (v < p + m) return dur_t'(p);
      if (v < 2 * p + m) return dur_t'(2 * p);
      return dur_t'(3 * p);
    endfunction

    function bit close_to(dur_t a, dur_t b);
      int unsigned d;
      d = (a > b) ? a - b : b - a;
      return d <= tol;
    endfunction

    function void add_event(evt_t e, logic [7:0] b);
      result_t r;
      r.evt = e;
      r.byte_value = b;
      r.last = 1'b0;
      item_events.push_back(r);
    endfunction

    // The newest cycle must be half the older one, and each cycle symmetric.
    function void test_prolog();
      logic nw;
      logic od;
      nw = newest;
      od = ~newest;
      if (fill < 2) return;
      epi_high = '0;
      if (close_to(hist_low[nw], hist_low[od] >> 1) &&
          close_to(hist_high[nw], hist_high[od] >> 1) &&
          close_to(hist_high[od], hist_low[od]) &&
          close_to(hist_high[nw], hist_low[nw])) begin
        phase = PH_FIRST_BIT;
        fill = '0;
        add_event(EV_PROLOG, 8'h00);
      end else begin
        add_event(EV_BAD_PROLOG, 8'h00);
      end
    endfunction

    function void decode_cycle(dur_t lo, dur_t hi);
      item_events.delete();
      if (phase > PH_EPILOG) phase = PH_PROLOG;
      if (phase == PH_PROLOG || phase == PH_EPILOG) begin
        lo = snap_dur(lo);
        hi = snap_dur(hi);
        newest = ~newest;
        hist_low[newest] = lo;
        hist_high[newest] = hi;
        if (fill < 2) fill++;
      end
      if (phase == PH_PROLOG) begin
        test_prolog();
      end else if (phase < PH_PARITY) begin
        if (hi > lo) shift_byte[phase - 1] = 1'b1;
        phase++;
      end else if (phase == PH_PARITY) begin
        parity_bit = hi > lo;
        phase++;
      end else if (epi_high == '0) begin
        epi_high = hi;
        epi_low = lo;
      end else begin
        if (close_to(epi_low, lo) && close_to(epi_high, hi)) begin
          // Odd parity over the byte and the parity bit together.
          if (parity_bit == ~^shift_byte) begin
            add_event(EV_BYTE, shift_byte);
            fill = '0;
          end else begin
            add_event(EV_BAD_PARITY, 8'h00);
          end
        end else begin
          add_event(EV_BAD_EPILOG, 8'h00);
        end
        phase = PH_PROLOG;
        shift_byte = '0;
        test_prolog();
      end
      if (item_events.size() > 0) item_events[item_events.size() - 1].last = 1'b1;
      foreach (item_events[i]) expected_events.push_back(item_events[i]);
    endfunction

    function void check_event(longint unsigned stamp, logic [2:0] ev, logic [7:0] b,
                              logic lst);
      result_t want;
      if (expected_events.size() == 0) begin
        errors++;
        $display("%0d ns: event %0d byte %02h last %0b arrived with none expected",
                 stamp, ev, b, lst);
        return;
      end
      want = expected_events.pop_front();
      if (ev !== want.evt) begin
        errors++;
        $display("%0d ns: event expected %0d actual %0d", stamp, want.evt, ev);
      end
      if (b !== want.byte_value) begin
        errors++;
        $display("%0d ns: byte_value expected %02h actual %02h", stamp, want.byte_value, b);
      end
      if (lst !== want.last) begin
        errors++;
        $display("%0d ns: last expected %0b actual %0b", stamp, want.last, lst);
      end
    endfunction

  endclass

endpackage

### dv/tb_top.sv
// Testbench top for wave_cycle_byte_decoder: drives wave cycles and register
// writes, checks the event stream against byte_frame_checker.
// Depends on wcbd_pkg, wcbd_frame_check_pkg and the decoder RTL.
module tb_top;

  timeunit 1ns;
  timeprecision 1ps;

  import wcbd_pkg::*;
  import wcbd_frame_check_pkg::*;

  localparam int CYCLE_LIMIT = 1_000_000;
  localparam int DRAIN_CYCLES = 8;
  localparam int UNUSED_REG_IDX = 3;

  logic              clk = 1'b0;
  logic              rst;
  logic              psel;
  logic              penable;
  logic              pwrite;
  logic [ADDR_W-1:0] paddr;
  logic [31:0]       pwdata;
  logic [31:0]       prdata;
  logic              pready;
  logic              s_axis_tvalid;
  logic              s_axis_tready;
  logic [31:0]       s_axis_tdata;
  logic              m_axis_tvalid;
  logic              m_axis_tready;
  logic [15:0]       m_axis_tdata;
  logic              m_axis_tlast;

  byte_frame_checker sb;
  int                sent = 0;
  int                cycle_count = 0;
  int                src_quiet = 0;
  int                snk_quiet = 0;

  wave_cycle_byte_decoder i_dut (
    .clk           (clk),
    .rst           (rst),
    .psel          (psel),
    .penable       (penable),
    .pwrite        (pwrite),
    .paddr         (paddr),
    .pwdata        (pwdata),
    .prdata        (prdata),
    .pready        (pready),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tlast  (m_axis_tlast)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == CYCLE_LIMIT) begin
      $display("FAILURE");
      $finish;
    end
  end

  always @(posedge clk) begin
    if (!rst) begin
      if (s_axis_tvalid && s_axis_tready)
        sb.decode_cycle(s_axis_tdata[15:0], s_axis_tdata[31:16]);
      if (m_axis_tvalid && m_axis_tready)
        sb.check_event($time, m_axis_tdata[2:0], m_axis_tdata[10:3], m_axis_tlast);
    end
  end

  // Mostly random waits, with occasional stretches of back-to-back transfers.
  function automatic int draw_gap(inout int quiet);
    if (quiet > 0) begin
      quiet--;
      return 0;
    end
    if ($urandom_range(0, 49) == 0) begin
      quiet = $urandom_range(20, 80);
      return 0;
    end
    return $urandom_range(0, 1) ? $urandom_range(0, 17) : $urandom_range(0, 2);
  endfunction

  // Result side: stall a random number of cycles before taking each result.
  initial begin
    int stall;
    m_axis_tready = 1'b0;
    while (rst !== 1'b0) @(posedge clk);
    forever begin
      stall = draw_gap(snk_quiet);
      if (stall > 0) begin
        m_axis_tready <= 1'b0;
        repeat (stall) @(posedge clk);
      end
      m_axis_tready <= 1'b1;
      do @(posedge clk); while (!m_axis_tvalid);
    end
  end

  // A duration that snaps to k bit periods under the current settings.
  function automatic dur_t periods(int k);
    int p;
    int m;
    int v;
    p = sb.period;
    m = (sb.margin < sb.period) ? sb.margin : sb.period;
    if (p == 0) return '0;
    v = (k - 1) * p + m + $urandom_range(0, p - 1);
    return (v > 65535) ? 16'hFFFF : dur_t'(v);
  endfunction

  task automatic send_cycle(dur_t lo, dur_t hi);
    int gap;
    gap = draw_gap(src_quiet);
    if (gap > 0) begin
      s_axis_tvalid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata <= {hi, lo};
    do @(posedge clk); while (!s_axis_tready);
    sent++;
  endtask

  task automatic send_bit(logic v);
    dur_t d;
    if ($urandom_range(0, 15) == 0) begin
      // Equal halves read as a zero bit.
      d = periods($urandom_range(1, 3));
      send_cycle(d, d);
    end else if (v) begin
      send_cycle(periods(1), periods(2));
    end else begin
      send_cycle(periods(2), periods(1));
    end
  endtask

  task automatic send_frame(logic [7:0] b, bit parity_ok, bit epilog_ok);
    int k;
    send_cycle(periods(2), periods(2));
    send_cycle(periods(1), periods(1));
    for (int i = 0; i < 8; i++) send_bit(b[i]);
    send_bit((~^b) ^ !parity_ok);
    k = $urandom_range(1, 3);
    send_cycle(periods(k), periods(k));
    if (epilog_ok) send_cycle(periods(k), periods(k));
    else send_cycle(periods(k % 3 + 1), periods(k));
  endtask

  task automatic send_noise();
    repeat ($urandom_range(1, 6)) begin
      case ($urandom_range(0, 2))
        0: send_cycle(dur_t'($urandom()), dur_t'($urandom()));
        1: send_cycle(periods($urandom_range(1, 3)), periods($urandom_range(1, 3)));
        default: send_cycle($urandom_range(0, 1) ? 16'hFFFF : 16'h0000,
                            $urandom_range(0, 1) ? 16'hFFFF : 16'h0000);
      endcase
    end
  endtask

  task automatic run_traffic(int n);
    int target;
    target = sent + n;
    while (sent < target) begin
      if ($urandom_range(0, 4) != 0)
        send_frame(8'($urandom()), $urandom_range(0, 4) != 0, $urandom_range(0, 6) != 0);
      else
        send_noise();
    end
  endtask

  // Quiet the input, let every expected result arrive, then let the pipeline drain.
  task automatic wait_idle();
    s_axis_tvalid <= 1'b0;
    @(posedge clk);
    while (sb.outstanding() > 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  // Each write returns the bus to idle before the next setup phase.
  task automatic apb_write(int idx, logic [CFG_W-1:0] value);
    logic [31:0] data;
    data = ($urandom() & 32'hFFFF_C000) | 32'(value);
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= 1'b1;
    paddr <= ADDR_W'(idx * 4);
    pwdata <= data;
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    psel <= 1'b0;
    penable <= 1'b0;
    pwrite <= 1'b0;
    sb.write_reg(idx, data);
    @(posedge clk);
  endtask

  task automatic set_config(int p, int m, int t);
    wait_idle();
    apb_write(REG_BIT_PERIOD, CFG_W'(p));
    apb_write(REG_SNAP_MARGIN, CFG_W'(m));
    apb_write(REG_TOLERANCE, CFG_W'(t));
  endtask

  task automatic random_config();
    int p;
    p = $urandom_range(8, 2000);
    set_config(p, $urandom_range(0, p), $urandom_range(0, p / 8));
  endtask

  initial begin
    sb = new();
    rst = 1'b1;
    psel = 1'b0;
    penable = 1'b0;
    pwrite = 1'b0;
    paddr = '0;
    pwdata = '0;
    s_axis_tvalid = 1'b0;
    s_axis_tdata = '0;
    repeat (8) @(posedge clk);
    rst <= 1'b0;

    send_cycle(16'h0000, 16'hFFFF);
    send_cycle(16'hFFFF, 16'h0000);
    send_frame(8'hA5, 1'b1, 1'b1);
    send_frame(8'h3C, 1'b0, 1'b1);
    run_traffic(500);

    set_config(1, 0, 0);
    run_traffic(250);
    set_config(16383, 16383, 16383);
    run_traffic(250);

    // A zero bit period snaps everything to zero, so the epilog never closes.
    set_config(0, 44, 7);
    apb_write(UNUSED_REG_IDX, CFG_W'($urandom()));
    run_traffic(40);

    repeat (4) begin
      random_config();
      run_traffic(250);
    end

    wait_idle();
    if (sb.errors == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end

endmodule
